@@ sv/time_optimal_servo_top_defines.svh @@
// assertion macros shared by the time-optimal servo rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef TIME_OPTIMAL_SERVO_TOP_DEFINES_SVH
`define TIME_OPTIMAL_SERVO_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define TOS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define TOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tos_pkg.sv @@
// shared types, widths and helpers for the time-optimal servo
// no dependencies
`default_nettype none
package tos_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int PERIOD_BITS = 16;
  localparam int PROD_W      = DATA_WIDTH + 1 + PERIOD_BITS + 2;
  localparam int SQRT_STEPS  = DATA_WIDTH;
  localparam int DIV_STEPS   = DATA_WIDTH + PERIOD_BITS;
  localparam int CNT_W       = 6;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    LC_BRAKE = 2'd0,
    LC_CAP   = 2'd1,
    LC_CLIP  = 2'd2
  } limit_case_e;

  // one classified item handed from front to back
  typedef struct packed {
    data_t                 err;
    data_t                 lim;
    logic [DATA_WIDTH-2:0] acc;
    data_t                 pred;
  } tos_item_t;

  function automatic logic [DATA_WIDTH:0] mag33(data_t x);
    mag33 = x[DATA_WIDTH-1] ? (33'd0 - {x[DATA_WIDTH-1], x}) : {1'b0, x};
  endfunction

  function automatic logic [PERIOD_BITS+1:0] triple(logic [PERIOD_BITS-1:0] p);
    triple = {2'b00, p} + {1'b0, p, 1'b0};
  endfunction

  // round |x|*3p/2^17 to nearest and apply the sign
  function automatic logic signed [34:0] la_signed(logic [PROD_W-1:0] prod, logic neg);
    logic [PROD_W-1:0] s;
    logic signed [34:0] r;
    s = prod + PROD_W'(1 << PERIOD_BITS);
    r = {1'b0, s[PROD_W-1:PERIOD_BITS+1]};
    la_signed = neg ? -r : r;
  endfunction

  function automatic data_t sat36(logic signed [35:0] v);
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      sat36 = v[31:0];
    end else if (v[35]) begin
      sat36 = 32'sh8000_0000;
    end else begin
      sat36 = 32'sh7FFF_FFFF;
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/tos_front.sv @@
// front end: takes items, forms the look-ahead prediction
// depends on tos_pkg
`default_nettype none
module tos_front import tos_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire data_t                  pos_error_i,
  input  wire data_t                  speed_limit_i,
  input  wire data_t                  current_speed_i,
  input  wire logic [DATA_WIDTH-2:0]  accel_limit_i,
  input  wire logic [PERIOD_BITS-1:0] period_i,
  input  wire logic                   q_full_i,
  output      logic                   push_o,
  output      tos_item_t              item_o
);

  logic                  a_v_q, a_v_d;
  data_t                 a_err_q, a_lim_q;
  logic [DATA_WIDTH-2:0] a_acc_q;
  logic                  a_neg_q;
  logic [PROD_W-1:0]     a_prod_q;
  logic                  take;
  logic signed [34:0]    la;
  logic signed [35:0]    sum;
  data_t                 pred;

  assign push_o     = a_v_q && !q_full_i;
  assign in_stall_o = a_v_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign a_v_d      = take ? 1'b1 : (push_o ? 1'b0 : a_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= a_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_err_q  <= pos_error_i;
      a_lim_q  <= speed_limit_i;
      a_acc_q  <= accel_limit_i;
      a_neg_q  <= current_speed_i[DATA_WIDTH-1];
      a_prod_q <= {18'd0, mag33(current_speed_i)} * {33'd0, triple(period_i)};
    end
  end

  always_comb begin
    la   = la_signed(a_prod_q, a_neg_q);
    sum  = {{4{a_err_q[DATA_WIDTH-1]}}, a_err_q} + {la[34], la};
    pred = sat36(sum);
    // prediction that crossed zero is forced to zero
    if ((pred > 0 && a_err_q < 0) || (pred < 0 && a_err_q > 0)) begin
      pred = '0;
    end
    item_o.err  = a_err_q;
    item_o.lim  = a_lim_q;
    item_o.acc  = a_acc_q;
    item_o.pred = pred;
  end

endmodule
`default_nettype wire

@@ sv/tos_queue.sv @@
// two-entry queue between front and back
// depends on tos_pkg and the defines header
`default_nettype none
`include "time_optimal_servo_top_defines.svh"
module tos_queue import tos_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire tos_item_t item_i,
  output      logic      full_o,
  input  wire logic      pop_i,
  output      logic      empty_o,
  output      tos_item_t item_o
);

  tos_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rd_q];
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  `TOS_ASSERT_ALWAYS(a_cnt_max, cnt_q != 2'd3, "queue count above depth")
  `TOS_ASSERT_ALWAYS(a_ptr_cnt, (cnt_q != 2'd1) || (wr_q != rd_q), "pointers disagree with count")
  `TOS_ASSERT_NEXT(a_no_over, push_i && !pop_i && cnt_q == 2'd1, full_o, "push lost")

endmodule
`default_nettype wire

@@ sv/tos_back.sv @@
// back end: braking speed, cap, overshoot clip and result register
// depends on tos_pkg and the defines header
`default_nettype none
`include "time_optimal_servo_top_defines.svh"
module tos_back import tos_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [PERIOD_BITS-1:0] period_i,
  input  wire logic                   q_empty_i,
  input  wire tos_item_t              item_i,
  output      logic                   pop_o,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      data_t                  speed_command_o,
  output      logic [1:0]             limit_case_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ITER = 5'b00100,
    ST_FIN1 = 5'b01000,
    ST_FIN2 = 5'b10000
  } state_e;

  state_e               st_q, st_d;
  tos_item_t            it_q;
  logic [63:0]          n_q;
  logic [34:0]          rem_q;
  logic [31:0]          root_q;
  logic [15:0]          drem_q;
  logic [47:0]          dvd_q, dq_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  data_t                cmd_q;
  logic                 cap_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 out_v_q, out_v_d;
  data_t                out_cmd_q;
  limit_case_e          out_lc_q;

  logic                 out_free, fin;
  logic [34:0]          rem_t, trial;
  logic [16:0]          dt;
  logic [DATA_WIDTH:0]  cap_mag, m, cmd_mag;
  logic                 big;
  data_t                cmd_c, fin_cmd;
  limit_case_e          fin_lc;
  logic signed [34:0]   la;
  logic signed [35:0]   test;
  logic [47:0]          q;
  logic [31:0]          pred_mag, err_mag;
  logic [62:0]          n_prod;

  assign out_free = !out_v_q || !out_stall_i;
  assign pop_o    = (st_q == ST_IDLE) && !q_empty_i;
  assign fin      = (st_q == ST_FIN2) && out_free;

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    case (st_q)
      ST_IDLE: if (!q_empty_i) st_d = ST_MUL;
      ST_MUL: begin
        st_d  = ST_ITER;
        cnt_d = '0;
      end
      ST_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) st_d = ST_FIN1;
      end
      ST_FIN1: st_d = ST_FIN2;
      ST_FIN2: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // magnitudes fit 32 bits, the most negative value gives 2^31
  always_comb begin
    pred_mag = 32'(mag33(it_q.pred));
    err_mag  = 32'(mag33(it_q.err));
    n_prod   = 63'(it_q.acc) * 63'(pred_mag);
  end

  // in the iterate state, one root bit and one quotient bit per cycle until each result is complete
  always_comb begin
    rem_t = {rem_q[32:0], n_q[63:62]};
    trial = {1'b0, root_q, 2'b01};
    dt    = {drem_q, dvd_q[47]};
  end

  always_comb begin
    cap_mag = mag33(it_q.lim);
    big     = {1'b0, root_q} > cap_mag;
    m       = big ? cap_mag : {1'b0, root_q};
    if (it_q.pred > 0) begin
      cmd_c = (m > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(33'd0 - m);
    end else if (it_q.pred < 0) begin
      cmd_c = (m > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
    end else begin
      cmd_c = '0;
    end
    cmd_mag = mag33(cmd_c);
  end

  always_comb begin
    la      = la_signed(prod_q, cmd_q[DATA_WIDTH-1]);
    test    = {{4{it_q.err[DATA_WIDTH-1]}}, it_q.err} + {la[34], la};
    q       = dq_q;
    fin_cmd = cmd_q;
    fin_lc  = cap_q ? LC_CAP : LC_BRAKE;
    if (period_i != '0 &&
        ((test > 0 && it_q.err < 0) || (test < 0 && it_q.err > 0))) begin
      fin_lc = LC_CLIP;
      if (it_q.err > 0) begin
        fin_cmd = (q > 48'h8000_0000) ? 32'sh8000_0000 : 32'(48'd0 - q);
      end else begin
        fin_cmd = (q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
      end
    end
  end

  assign out_v_d = fin ? 1'b1 : (out_stall_i ? out_v_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= item_i;
    if (st_q == ST_MUL) begin
      n_q    <= {n_prod, 1'b0};
      rem_q  <= '0;
      root_q <= '0;
      drem_q <= '0;
      dvd_q  <= {err_mag, 16'd0};
      dq_q   <= '0;
    end
    if (st_q == ST_ITER) begin
      if (cnt_q < CNT_W'(SQRT_STEPS)) begin
        n_q <= {n_q[61:0], 2'b00};
        if (rem_t >= trial) begin
          rem_q  <= rem_t - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_t;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      dvd_q <= {dvd_q[46:0], 1'b0};
      if (dt >= {1'b0, period_i}) begin
        drem_q <= 16'(dt - {1'b0, period_i});
        dq_q   <= {dq_q[46:0], 1'b1};
      end else begin
        drem_q <= dt[15:0];
        dq_q   <= {dq_q[46:0], 1'b0};
      end
    end
    if (st_q == ST_FIN1) begin
      cmd_q  <= cmd_c;
      cap_q  <= big;
      prod_q <= {18'd0, cmd_mag} * {33'd0, triple(period_i)};
    end
    if (fin) begin
      out_cmd_q <= fin_cmd;
      out_lc_q  <= fin_lc;
    end
  end

  assign out_valid_o     = out_v_q;
  assign speed_command_o = out_cmd_q;
  assign limit_case_o    = out_lc_q;

  `TOS_ASSERT_ALWAYS(a_lc_code, !out_v_q || out_lc_q != 2'd3, "bad limit case")
  `TOS_ASSERT_ALWAYS(a_cnt_rng, cnt_q <= CNT_W'(DIV_STEPS), "iteration count out of range")
  `TOS_ASSERT_NEXT(a_hold, out_v_q && out_stall_i, out_v_q && $stable(out_cmd_q), "result dropped")

endmodule
`default_nettype wire

@@ sv/time_optimal_servo_top.sv @@
// time-optimal servo: one speed command per item
// the back end takes a new item only once it is done with the last, paced by the 48-step
// restoring divider that runs alongside the 32-step square root
// front stage and a two-entry queue accept further items while the back end works
// reset: asynchronous active low, clears control state, control_period to 328
`default_nettype none
module time_optimal_servo_top import tos_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire data_t                  pos_error_i,
  input  wire data_t                  speed_limit_i,
  input  wire data_t                  current_speed_i,
  input  wire logic [DATA_WIDTH-2:0]  accel_limit_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      data_t                  speed_command_o,
  output      logic [1:0]             limit_case_o,
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [PERIOD_BITS-1:0] cfg_data_i
);

  logic [PERIOD_BITS-1:0] period_q;
  logic                   push, pop, full, empty;
  tos_item_t              f_item, q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_BITS'(328);
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  tos_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pos_error_i, .speed_limit_i, .current_speed_i, .accel_limit_i,
    .period_i (period_q),
    .q_full_i (full),
    .push_o   (push),
    .item_o   (f_item)
  );

  tos_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (q_item)
  );

  tos_back u_back (
    .clk_i, .rst_ni,
    .period_i  (period_q),
    .q_empty_i (empty),
    .item_i    (q_item),
    .pop_o     (pop),
    .out_valid_o, .out_stall_i, .speed_command_o, .limit_case_o
  );

endmodule
`default_nettype wire
